@@ hw/rtl/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg
// shared constants, command codes and controller/datapath interface types
// for the permutation shuffle engine
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int TABLE_SIZE = 52;
	localparam int IDX_W      = 6;
	localparam int RAND_W     = 32;
	localparam int REM_W      = IDX_W + 1;
	localparam int CNT_W      = $clog2(RAND_W);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RAND_W - 1);

	// command codes
	localparam logic [1:0] CMD_RESTORE = 2'd0;
	localparam logic [1:0] CMD_STEP    = 2'd1;
	localparam logic [1:0] CMD_DUMP    = 2'd2;

	// read address select
	localparam logic [1:0] RD_SEL_I    = 2'd0;
	localparam logic [1:0] RD_SEL_J    = 2'd1;
	localparam logic [1:0] RD_SEL_DUMP = 2'd2;

	typedef struct packed {
		logic       restore;
		logic       step_start;
		logic       dump_clr;
		logic       mod_en;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       latch_vi;
		logic       wr_i;
		logic       wr_j;
		logic       load_res;
		logic       load_dump;
		logic       dump_inc;
	} pse_ctl_t;

	typedef struct packed {
		logic dump_last;
	} pse_sts_t;

endpackage

@@ hw/rtl/pse_datapath.sv @@
// ----------------------------------------------------------------------------
// pse_datapath
// card table memory with valid bits, step index, bit-serial modulo unit,
// swap registers and the output payload register
// ----------------------------------------------------------------------------
module pse_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pse_pkg::pse_ctl_t       ctl,
	output pse_pkg::pse_sts_t       sts,
	input  logic [31:0]             rand_value,
	output logic [pse_pkg::IDX_W-1:0] position,
	output logic [pse_pkg::IDX_W-1:0] card,
	output logic                    pass_done,
	output logic                    last
);
	import pse_pkg::*;

	logic [IDX_W-1:0]      mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] vld_q;

	logic [IDX_W-1:0]  step_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  i_eff;
	logic [RAND_W-1:0] rnd_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  div;
	logic [REM_W-1:0]  trial;
	logic [REM_W-1:0]  rem_nxt;
	logic [IDX_W-1:0]  j;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] rd_addr_q;
	logic [IDX_W-1:0] rd_data_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_card;
	logic [IDX_W-1:0] vi_q;

	logic [IDX_W-1:0] dump_q;
	logic [IDX_W-1:0] res_pos_q;
	logic [IDX_W-1:0] res_card_q;
	logic             res_done_q;

	logic [IDX_W-1:0] position_q;
	logic [IDX_W-1:0] card_q;
	logic             pass_done_q;
	logic             last_q;

	// step index is reloaded if ever out of range
	assign i_eff = (step_q == '0 || step_q > LAST_IDX) ? LAST_IDX : step_q;

	// restoring modulo, one dividend bit a cycle
	assign div     = REM_W'(i_q) + REM_W'(1);
	assign trial   = {rem_q[IDX_W-1:0], rnd_q[RAND_W-1]};
	assign rem_nxt = (trial >= div) ? (trial - div) : trial;
	assign j       = rem_q[IDX_W-1:0];

	always_comb begin
		case (ctl.rd_sel)
			RD_SEL_I:    rd_addr = i_q;
			RD_SEL_J:    rd_addr = j;
			RD_SEL_DUMP: rd_addr = dump_q;
			default:     rd_addr = i_q;
		endcase
	end

	// unwritten entries read as their own index
	assign rd_card = rd_vld_q ? rd_data_q : rd_addr_q;

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (ctl.wr_i) begin
			mem[i_q] <= rd_card;
		end else if (ctl.wr_j) begin
			mem[j] <= vi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			step_q <= LAST_IDX;
		end else begin
			if (ctl.restore) begin
				vld_q  <= '0;
				step_q <= LAST_IDX;
			end else begin
				if (ctl.wr_i) vld_q[i_q] <= 1'b1;
				if (ctl.wr_j) vld_q[j]   <= 1'b1;
				if (ctl.step_start) begin
					step_q <= (i_eff == IDX_W'(1)) ? LAST_IDX : (i_eff - IDX_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_vld_q  <= vld_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (ctl.latch_vi) vi_q <= rd_card;
		if (ctl.step_start) begin
			i_q        <= i_eff;
			rnd_q      <= rand_value;
			rem_q      <= '0;
			res_pos_q  <= i_eff;
			res_done_q <= (i_eff == IDX_W'(1));
		end else if (ctl.mod_en) begin
			rnd_q <= {rnd_q[RAND_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
		if (ctl.wr_i) res_card_q <= rd_card;
		if (ctl.restore) begin
			res_pos_q  <= LAST_IDX;
			res_card_q <= LAST_IDX;
			res_done_q <= 1'b0;
		end
		if (ctl.dump_clr) begin
			dump_q <= '0;
		end else if (ctl.dump_inc) begin
			dump_q <= dump_q + IDX_W'(1);
		end
		if (ctl.load_res) begin
			position_q  <= res_pos_q;
			card_q      <= res_card_q;
			pass_done_q <= res_done_q;
			last_q      <= 1'b1;
		end else if (ctl.load_dump) begin
			position_q  <= dump_q;
			card_q      <= rd_card;
			pass_done_q <= 1'b0;
			last_q      <= (dump_q == LAST_IDX);
		end
	end

	assign sts.dump_last = (dump_q == LAST_IDX);
	assign position      = position_q;
	assign card          = card_q;
	assign pass_done     = pass_done_q;
	assign last          = last_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 && step_q <= LAST_IDX)
		else $error("step index out of range");

	a_swap_partner: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_i |-> j <= i_q)
		else $error("swap partner beyond step index");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mod_en |=> rem_q < div)
		else $error("modulo remainder not reduced");

endmodule

@@ hw/rtl/pse_ctrl.sv @@
// ----------------------------------------------------------------------------
// pse_ctrl
// command sequencer: modulo iterations, swap read/write order, dump walk and
// output register handshake
// ----------------------------------------------------------------------------
module pse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output pse_pkg::pse_ctl_t ctl,
	input  pse_pkg::pse_sts_t sts
);
	import pse_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MOD       = 4'd1;
	localparam logic [3:0] ST_RD_I      = 4'd2;
	localparam logic [3:0] ST_RD_J      = 4'd3;
	localparam logic [3:0] ST_WR_I      = 4'd4;
	localparam logic [3:0] ST_WR_J      = 4'd5;
	localparam logic [3:0] ST_EMIT      = 4'd6;
	localparam logic [3:0] ST_DUMP_RD   = 4'd7;
	localparam logic [3:0] ST_DUMP_WAIT = 4'd8;

	logic [3:0]       state_q;
	logic [3:0]       state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		ctl       = '0;
		ctl.rd_sel = RD_SEL_I;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_RESTORE: begin
							ctl.restore = 1'b1;
							state_nxt   = ST_EMIT;
						end
						CMD_STEP: begin
							ctl.step_start = 1'b1;
							state_nxt      = ST_MOD;
						end
						CMD_DUMP: begin
							ctl.dump_clr = 1'b1;
							state_nxt    = ST_DUMP_RD;
						end
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_MOD: begin
				ctl.mod_en = 1'b1;
				if (cnt_q == CNT_LAST) state_nxt = ST_RD_I;
			end
			ST_RD_I: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_SEL_I;
				state_nxt  = ST_RD_J;
			end
			ST_RD_J: begin
				ctl.rd_en    = 1'b1;
				ctl.rd_sel   = RD_SEL_J;
				ctl.latch_vi = 1'b1;
				state_nxt    = ST_WR_I;
			end
			ST_WR_I: begin
				ctl.wr_i  = 1'b1;
				state_nxt = ST_WR_J;
			end
			ST_WR_J: begin
				ctl.wr_j  = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					ctl.load_res = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			ST_DUMP_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_SEL_DUMP;
				state_nxt  = ST_DUMP_WAIT;
			end
			ST_DUMP_WAIT: begin
				ctl.rd_sel = RD_SEL_DUMP;
				if (out_free) begin
					ctl.load_dump = 1'b1;
					if (sts.dump_last) begin
						state_nxt = ST_IDLE;
					end else begin
						ctl.dump_inc = 1'b1;
						state_nxt    = ST_DUMP_RD;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.step_start) begin
				cnt_q <= '0;
			end else if (ctl.mod_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctl.load_res || ctl.load_dump) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load_res || ctl.load_dump) |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	a_mod_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD && cnt_q == CNT_LAST) |=> state_q == ST_RD_I)
		else $error("modulo iteration count wrong");

endmodule

@@ hw/rtl/permutation_shuffle_engine.sv @@
// ----------------------------------------------------------------------------
// permutation_shuffle_engine
// fisher-yates card table: restore, single shuffle step and table dump
// ----------------------------------------------------------------------------
// sequence: restore goes straight to the output load; a step runs one modulo
//   iteration per random bit, two table reads, two writes and one output load
// throughput: one transaction at a time; a step is paced by the one-bit-a-cycle
//   modulo and the single table port; a dump reads out one position at a time
// reset: arst_n clears control and valid bits at once, table reads as identity
//   order and the step index reloads to the last position; no clearing pass
module permutation_shuffle_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                cmd,
	input  logic [31:0]               rand_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pse_pkg::IDX_W-1:0] position,
	output logic [pse_pkg::IDX_W-1:0] card,
	output logic                      pass_done,
	output logic                      last
);
	import pse_pkg::*;

	// command and status between sequencer and datapath
	pse_ctl_t ctl;
	pse_sts_t sts;

	// sequencer: accepts a transaction only when idle, walks the command
	pse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// datapath: card table, modulo unit and output payload register
	pse_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.rand_value (rand_value),
		.position   (position),
		.card       (card),
		.pass_done  (pass_done),
		.last       (last)
	);

	// a result at the last position always ends its transaction
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> position < LAST_IDX)
		else $error("non-final result at last position");

	// a completed pass is only flagged on a single-result transaction
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pass_done) |-> (last && position == IDX_W'(1)))
		else $error("pass done on wrong result");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives restore, shuffle step, dump and unused command transactions into the
// permutation shuffle engine and checks every reported position against a
// card table tracked in the bench, with random idling on both sides
// ----------------------------------------------------------------------------
module testbench;
	import pse_pkg::*;

	// the package names the three live codes, the fourth is ignored by the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int IDLE_PCT     = 31;
	localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES = 80;    // extra wait after the last owed entry
	localparam int CALM_ITEMS   = 40;
	localparam int MIX_ITEMS    = 100;

	// one reported table entry
	typedef struct {
		logic [IDX_W-1:0] position;
		logic [IDX_W-1:0] card;
		logic             pass_done;
		logic             last;
	} deal_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        cmd;
	logic [31:0]       rand_value;
	logic              out_valid;
	logic              out_ready;
	logic [IDX_W-1:0]  position;
	logic [IDX_W-1:0]  card;
	logic              pass_done;
	logic              last;

	// bench copy of the card table and the fisher-yates step index
	logic [IDX_W-1:0]  deck [TABLE_SIZE];
	logic [IDX_W-1:0]  swap_idx;

	// entries still owed by the block, oldest first
	deal_t             cards_due[$];

	int                err_count = 0;
	int                idle_pct  = IDLE_PCT;
	int                hold_req  = 0;   // bumped to ask the receiver for a long hold-off

	permutation_shuffle_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.rand_value (rand_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.position   (position),
		.card       (card),
		.pass_done  (pass_done),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one printed line per mismatch, counted for the final verdict
	task automatic report_error(input string what);
		err_count++;
		$display("error at %0t ns: %s", $time, what);
	endtask

	// identity order, step index back at the last position
	task automatic stack_identity();
		for (int k = 0; k < TABLE_SIZE; k++)
			deck[k] = IDX_W'(k);
		swap_idx = LAST_IDX;
	endtask

	// updates the bench table for one accepted command and queues what it reports
	task automatic predict_deal(input logic [1:0] op, input logic [31:0] word);
		deal_t            d;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] held;
		int unsigned      span;
		case (op)
			CMD_RESTORE: begin
				stack_identity();
				d.position  = LAST_IDX;
				d.card      = deck[LAST_IDX];
				d.pass_done = 1'b0;
				d.last      = 1'b1;
				cards_due.push_back(d);
			end
			CMD_STEP: begin
				// a stale index reloads before use, the commands never produce one
				if (swap_idx == '0 || swap_idx >= TABLE_SIZE)
					swap_idx = LAST_IDX;
				i    = swap_idx;
				span = i + 1;
				j    = IDX_W'(word % span);
				held    = deck[i];
				deck[i] = deck[j];
				deck[j] = held;
				swap_idx    = i - 1'b1;
				d.pass_done = (swap_idx == '0);
				// pass complete: the next step starts over at the top
				if (d.pass_done)
					swap_idx = LAST_IDX;
				d.position = i;
				d.card     = deck[i];
				d.last     = 1'b1;
				cards_due.push_back(d);
			end
			CMD_DUMP: begin
				for (int k = 0; k < TABLE_SIZE; k++) begin
					d.position  = IDX_W'(k);
					d.card      = deck[k];
					d.pass_done = 1'b0;
					d.last      = (k == TABLE_SIZE - 1);
					cards_due.push_back(d);
				end
			end
			default: begin
				// unused code: no state change, nothing reported
			end
		endcase
	endtask

	// offers one transaction and returns at the edge that accepts it
	task automatic offer_command(input logic [1:0] op, input logic [31:0] word);
		@(negedge clk);
		// random gaps before the item, valid low while idling
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		rand_value <= word;
		do
			@(posedge clk);
		while (!in_ready);
		predict_deal(op, word);
	endtask

	// random words with extra weight on zero, all ones and small values
	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return 32'($urandom_range(63));
			default: return $urandom;
		endcase
	endfunction

	// mostly steps, some dumps, rare restores and unused codes
	function automatic logic [1:0] pick_command();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return CMD_RESTORE;
		else if (r < 78)
			return CMD_STEP;
		else if (r < 90)
			return CMD_DUMP;
		else
			return CMD_UNUSED;
	endfunction

	// field extremes, self swaps and the dump right after reset
	task automatic test_directed_edges();
		offer_command(CMD_DUMP,    32'h0000_0000);   // identity order out of reset
		offer_command(CMD_STEP,    32'h0000_0000);   // last position swaps with the first
		offer_command(CMD_STEP,    32'hFFFF_FFFF);
		offer_command(CMD_STEP,    32'd49);          // index 49 swaps with itself
		offer_command(CMD_STEP,    32'h8000_0000);
		offer_command(CMD_STEP,    32'h7FFF_FFFF);
		offer_command(CMD_DUMP,    32'h0000_0000);
		offer_command(CMD_RESTORE, 32'hFFFF_FFFF);   // word is don't-care here
		offer_command(CMD_DUMP,    32'h5A5A_5A5A);
	endtask

	// unused code must leave the table and index alone
	task automatic test_ignored_code();
		offer_command(CMD_UNUSED, 32'hFFFF_FFFF);
		offer_command(CMD_UNUSED, 32'h0000_0000);
		offer_command(CMD_STEP,   32'd51);           // top index swaps with itself
		offer_command(CMD_UNUSED, 32'h1234_5678);
		offer_command(CMD_DUMP,   32'h0000_0000);
	endtask

	// a whole pass: pass_done on the last step, then wrap back to the top
	task automatic test_full_pass();
		offer_command(CMD_RESTORE, pick_word());
		for (int s = 0; s < TABLE_SIZE - 1; s++)
			offer_command(CMD_STEP, pick_word());
		offer_command(CMD_DUMP, pick_word());
		offer_command(CMD_STEP, pick_word());
		offer_command(CMD_STEP, pick_word());
	endtask

	// receiver holds off long enough for the block to back up into its input
	task automatic test_backpressure();
		hold_req++;
		offer_command(CMD_DUMP,    pick_word());
		offer_command(CMD_STEP,    pick_word());
		offer_command(CMD_DUMP,    pick_word());
		offer_command(CMD_DUMP,    pick_word());
		offer_command(CMD_RESTORE, pick_word());
		offer_command(CMD_DUMP,    pick_word());
	endtask

	// back-to-back stretch, neither side idles
	task automatic test_calm_stream();
		idle_pct = 0;
		for (int n = 0; n < CALM_ITEMS; n++)
			offer_command(pick_command(), pick_word());
		idle_pct = IDLE_PCT;
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < MIX_ITEMS; n++)
			offer_command(pick_command(), pick_word());
	endtask

	// receiver side: random stalls, plus the long hold-off on request
	initial begin : drive_out_ready
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// every accepted result transaction is matched against the oldest entry owed
	always @(posedge clk) begin : check_deals
		deal_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cards_due.size() == 0) begin
				report_error($sformatf("unexpected result position %0d card %0d",
					position, card));
			end else begin
				want = cards_due.pop_front();
				if (position !== want.position)
					report_error($sformatf("position %0d, want %0d",
						position, want.position));
				if (card !== want.card)
					report_error($sformatf("card %0d at position %0d, want %0d",
						card, want.position, want.card));
				if (pass_done !== want.pass_done)
					report_error($sformatf("pass_done %b at position %0d, want %b",
						pass_done, want.position, want.pass_done));
				if (last !== want.last)
					report_error($sformatf("last %b at position %0d, want %b",
						last, want.position, want.last));
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = CMD_RESTORE;
		rand_value = '0;
		stack_identity();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_ignored_code();
		test_full_pass();
		test_backpressure();
		test_calm_stream();
		test_random_mix();

		// stop offering, let everything owed come out, then allow for stragglers
		@(negedge clk);
		in_valid <= 1'b0;
		while (cards_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
